/* src/ttcg_pkg.sv */
// Shared types and constants for the text terminal character generator.
// No dependencies; used by ttcg_raster and the top level.
package ttcg_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_FETCH = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } ttcg_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_CLEAR,
    S_SCROLL,
    S_MARK,
    S_FETCH,
    S_RESULT
  } ttcg_state_t;

  // Character codes
  localparam logic [7:0] BLANK_CODE     = 8'd32;
  localparam logic [7:0] CURSOR_CODE    = 8'd219;
  localparam logic [7:0] CODE_CLEAR     = 8'd12;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;

  // Glyph scanline index width; font address is {scanline, code}
  localparam int GLINE_W = 4;
  localparam int FONT_AW = GLINE_W + 8;

  // Fetch sequence steps: cells read in steps 0..3, glyph bytes land in 2..5
  localparam int FS_W = 3;
  localparam logic [FS_W-1:0] FS_FIRST_BYTE = 3'd2;
  localparam logic [FS_W-1:0] FS_LAST       = 3'd5;

  // Raster walker status for the current word position
  typedef struct packed {
    logic line_end;
    logic frame_end;
  } ttcg_walk_flags_t;

endpackage

/* src/text_terminal_character_generator_top.sv */
// Text terminal character generator top level: screen and font memories,
// request sequencer and result register. Depends on ttcg_pkg, ttcg_raster.
//
// Usage: requests arrive on the in_ channel (valid/ready); each request gives
// exactly one result on the out_ channel (valid/ready), in order.
//   put character : writes the cell, then the cursor mark, then the result; a clear
//                   first blanks every cell, a scroll first moves each row up and
//                   blanks the bottom row (one cell per cycle through the screen memory).
//   fetch         : the four cells and four glyph bytes go in series through the
//                   single read port of each memory, and each read is registered;
//                   the next request is taken only after the result step.
//   load font     : writes the font byte on acceptance, then gives the result.
// Results sit in an output register; a new request is taken while a result
// waits, and only the result step stalls until the receiver takes it.
// After reset the screen memory is filled with spaces, one cell per cycle
// (all COLUMNS*ROWS cells, 768 by default); in_ready stays low meanwhile.
// The font memory is not initialized; load each glyph byte before fetching it.
module text_terminal_character_generator_top
  import ttcg_pkg::*;
#(
  parameter int COLUMNS     = 48,
  parameter int ROWS        = 16,
  parameter int GLYPH_LINES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [11:0] in_font_index,
  input  logic [7:0]  in_font_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_word,
  output logic        out_line_end,
  output logic        out_frame_end,
  output logic [5:0]  out_cursor_column,
  output logic [3:0]  out_cursor_row
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int WPL        = (COLUMNS + 3) / 4;
  localparam int WW         = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;

  ttcg_state_t       state_r, state_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic [FS_W-1:0]   fs_r, fs_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  ttcg_op_t          op_r;
  logic [7:0]        code_r;

  logic              in_fire;
  logic              res_load;
  logic              advance;

  // Put-character cursor arithmetic
  logic [CW:0]       col_put;
  logic [RW:0]       row_put;
  logic              scroll_need;
  logic [RW-1:0]     row_fin;
  logic [AW-1:0]     cur_addr;

  // Screen memory
  logic [7:0]        scr_mem [CELL_COUNT];
  logic              scr_we;
  logic [AW-1:0]     scr_waddr;
  logic [7:0]        scr_wdata;
  logic [AW-1:0]     scr_raddr;
  logic [7:0]        scr_q;
  logic [AW:0]       dst_idx;
  logic [AW+1:0]     src_idx;
  logic [AW:0]       fetch_idx;

  // Font memory
  logic [7:0]        font_mem [2**FONT_AW];
  logic              font_we;
  logic [FONT_AW-1:0] font_raddr;
  logic [7:0]        font_q;

  // Fetch assembly
  logic [AW-1:0]     scan_addr;
  logic [WW-1:0]     word_idx;
  logic [GLINE_W-1:0] gline;
  ttcg_walk_flags_t  walk_flags;
  logic [1:0]        byte_k;
  logic              col_ok;
  logic [7:0]        fetch_byte;
  logic [23:0]       acc_r;
  logic [31:0]       pix_r;
  logic              lend_r, fend_r;

  // Result register
  logic              out_valid_r;
  logic [31:0]       out_pixel_word_r;
  logic              out_line_end_r, out_frame_end_r;
  logic [5:0]        out_cursor_column_r;
  logic [3:0]        out_cursor_row_r;

  ttcg_raster #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .GLYPH_LINES(GLYPH_LINES)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance_i  (advance),
    .scan_addr_o(scan_addr),
    .word_o     (word_idx),
    .gline_o    (gline),
    .flags_o    (walk_flags)
  );

  assign in_fire = in_valid && in_ready;

  // Cursor cell address
  assign cur_addr = AW'(32'(row_r) * COLUMNS + 32'(col_r));

  // New cursor position for a put-character request
  always_comb begin
    col_put = {1'b0, col_r};
    row_put = {1'b0, row_r};
    priority if (code_r == CODE_CLEAR) begin
      col_put = '0;
      row_put = '0;
    end else if (code_r == CODE_NEWLINE) begin
      col_put = '0;
      row_put = {1'b0, row_r} + 1'b1;
    end else if (code_r == CODE_BACKSPACE) begin
      if (col_r != '0) col_put = {1'b0, col_r} - 1'b1;
    end else begin
      col_put = {1'b0, col_r} + 1'b1;
    end
    if (col_put >= (CW+1)'(COLUMNS)) begin
      col_put = '0;
      row_put = row_put + 1'b1;
    end
  end

  assign scroll_need = (row_put >= (RW+1)'(ROWS));
  assign row_fin     = scroll_need ? RW'(ROWS - 1) : row_put[RW-1:0];

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    fs_nxt    = '0;
    col_nxt   = col_r;
    row_nxt   = row_r;
    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (ttcg_op_t'(in_operation))
            OP_PUT:   state_nxt = S_PUT;
            OP_FETCH: state_nxt = S_FETCH;
            OP_LOAD,
            OP_NONE:  state_nxt = S_RESULT;
          endcase
        end
      end
      S_PUT: begin
        col_nxt = col_put[CW-1:0];
        row_nxt = row_fin;
        priority if (code_r == CODE_CLEAR) state_nxt = S_CLEAR;
        else if (scroll_need)              state_nxt = S_SCROLL;
        else                               state_nxt = S_MARK;
      end
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MARK;
        end
      end
      S_SCROLL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(CELL_COUNT)) begin
          cnt_nxt   = '0;
          state_nxt = S_MARK;
        end
      end
      S_MARK: state_nxt = S_RESULT;
      S_FETCH: begin
        fs_nxt = fs_r + 1'b1;
        if (fs_r == FS_LAST) begin
          fs_nxt    = '0;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    advance  = (state_r == S_FETCH) && (fs_r == FS_LAST);
    res_load = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  end

  // Screen memory write port
  assign dst_idx = cnt_r - 1'b1;
  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = cur_addr;
    scr_wdata = BLANK_CODE;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = cnt_r[AW-1:0];
      end
      S_PUT: begin
        if (code_r != CODE_CLEAR) begin
          scr_we    = 1'b1;
          scr_wdata = (code_r == CODE_NEWLINE || code_r == CODE_BACKSPACE) ?
                      BLANK_CODE : code_r;
        end
      end
      S_SCROLL: begin
        // cell i takes cell i+COLUMNS read the cycle before; bottom row blanks
        if (cnt_r != '0) begin
          scr_we    = 1'b1;
          scr_waddr = dst_idx[AW-1:0];
          scr_wdata = (dst_idx < (AW+1)'(CELL_COUNT - COLUMNS)) ? scr_q : BLANK_CODE;
        end
      end
      S_MARK: begin
        scr_we    = 1'b1;
        scr_wdata = CURSOR_CODE;
      end
      default: ;
    endcase
  end

  // Screen memory read address
  assign src_idx   = (AW+2)'(cnt_r) + (AW+2)'(COLUMNS);
  assign fetch_idx = (AW+1)'(scan_addr) + (AW+1)'(fs_r);
  always_comb begin
    scr_raddr = '0;
    if (state_r == S_SCROLL) begin
      if (src_idx < (AW+2)'(CELL_COUNT)) scr_raddr = src_idx[AW-1:0];
    end else if (state_r == S_FETCH) begin
      if (fetch_idx < (AW+1)'(CELL_COUNT)) scr_raddr = fetch_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_q <= scr_mem[scr_raddr];
  end

  // Font memory: written by load requests, read with the cell code just fetched
  assign font_we    = in_fire && (ttcg_op_t'(in_operation) == OP_LOAD);
  assign font_raddr = {gline, scr_q};

  always_ff @(posedge clk) begin
    if (font_we) font_mem[in_font_index] <= in_font_data;
    font_q <= font_mem[font_raddr];
  end

  // Glyph byte for the current step, zero past the end of the row
  assign byte_k     = 2'(fs_r - FS_FIRST_BYTE);
  assign col_ok     = (CW+1)'({word_idx, byte_k}) < (CW+1)'(COLUMNS);
  assign fetch_byte = col_ok ? font_q : 8'd0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      fs_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fs_r    <= fs_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (res_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Request capture, word assembly and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= ttcg_op_t'(in_operation);
      code_r <= in_char_code;
    end
    if (state_r == S_FETCH && fs_r >= FS_FIRST_BYTE) begin
      acc_r <= {acc_r[15:0], fetch_byte};
    end
    if (advance) begin
      pix_r  <= {acc_r, fetch_byte};
      lend_r <= walk_flags.line_end;
      fend_r <= walk_flags.frame_end;
    end
    if (res_load) begin
      out_pixel_word_r    <= (op_r == OP_FETCH) ? pix_r : 32'd0;
      out_line_end_r      <= (op_r == OP_FETCH) && lend_r;
      out_frame_end_r     <= (op_r == OP_FETCH) && fend_r;
      out_cursor_column_r <= 6'(col_r);
      out_cursor_row_r    <= 4'(row_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_word    = out_pixel_word_r;
  assign out_line_end      = out_line_end_r;
  assign out_frame_end     = out_frame_end_r;
  assign out_cursor_column = out_cursor_column_r;
  assign out_cursor_row    = out_cursor_row_r;

`ifndef SYNTHESIS
  // Cursor stays on the screen
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(col_r) < (CW+1)'(COLUMNS))
    else $error("cursor column past last column");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (RW+1)'(row_r) < (RW+1)'(ROWS))
    else $error("cursor row past last row");

  // A frame end is always also a line end
  a_frame_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_line_end_r)
    else $error("frame end without line end");

  // Screen is never written while idle or fetching
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    scr_we |-> (state_r != S_IDLE) && (state_r != S_FETCH))
    else $error("screen write outside a put or clear sequence");
`endif

endmodule

/* src/ttcg_raster.sv */
// Raster walker: tracks which four cells and which glyph scanline the next
// fetch word covers. Depends on ttcg_pkg.
module ttcg_raster
  import ttcg_pkg::*;
#(
  parameter int COLUMNS     = 48,
  parameter int ROWS        = 16,
  parameter int GLYPH_LINES = 16,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int AW         = $clog2(CELL_COUNT),
  localparam int WPL        = (COLUMNS + 3) / 4,
  localparam int WW         = (WPL > 1) ? $clog2(WPL) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance_i,
  output logic [AW-1:0]          scan_addr_o,
  output logic [WW-1:0]          word_o,
  output logic [GLINE_W-1:0]     gline_o,
  output ttcg_walk_flags_t       flags_o
);

  logic [AW-1:0]      scan_r, scan_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [WW-1:0]      word_r, word_nxt;
  logic [GLINE_W-1:0] gline_r, gline_nxt;
  logic [AW:0]        next_row_base;
  logic               last_gline;

  // Status of the current position
  assign next_row_base     = (AW+1)'(base_r) + (AW+1)'(COLUMNS);
  assign last_gline        = (gline_r == GLINE_W'(GLYPH_LINES - 1));
  assign flags_o.line_end  = (word_r == WW'(WPL - 1));
  assign flags_o.frame_end = flags_o.line_end && last_gline &&
                             (next_row_base >= (AW+1)'(CELL_COUNT));

  // Step to the next word, scanline or row
  always_comb begin
    scan_nxt  = scan_r;
    base_nxt  = base_r;
    word_nxt  = word_r;
    gline_nxt = gline_r;
    if (advance_i) begin
      if (!flags_o.line_end) begin
        word_nxt = word_r + 1'b1;
        scan_nxt = scan_r + AW'(4);
      end else begin
        word_nxt = '0;
        if (!last_gline) begin
          gline_nxt = gline_r + 1'b1;
          scan_nxt  = base_r;
        end else begin
          gline_nxt = '0;
          base_nxt  = flags_o.frame_end ? '0 : next_row_base[AW-1:0];
          scan_nxt  = base_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      base_r  <= '0;
      word_r  <= '0;
      gline_r <= '0;
    end else begin
      scan_r  <= scan_nxt;
      base_r  <= base_nxt;
      word_r  <= word_nxt;
      gline_r <= gline_nxt;
    end
  end

  assign scan_addr_o = scan_r;
  assign word_o      = word_r;
  assign gline_o     = gline_r;

`ifndef SYNTHESIS
  // Word pointer stays on the row start plus four cells per word
  a_scan_tracks_word: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+WW+3)'(scan_r) == (AW+WW+3)'(base_r) + (AW+WW+3)'({word_r, 2'b00}))
    else $error("scan address out of step with word index");

  // Row base stays inside the screen
  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(base_r) < (AW+1)'(CELL_COUNT))
    else $error("row base past end of screen");

  // Glyph scanline wraps at the font height
  a_gline_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (GLINE_W+1)'(gline_r) < (GLINE_W+1)'(GLYPH_LINES))
    else $error("glyph scanline past font height");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for text_terminal_character_generator_top: random and
// directed requests, an in-order screen/font predictor and per-field compare.
// Depends on ttcg_pkg and the top-level RTL only.
module testbench;
  import ttcg_pkg::*;

  localparam int COLUMNS        = 48;
  localparam int ROWS           = 16;
  localparam int GLYPH_LINES    = 16;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int WORDS_PER_LINE = (COLUMNS + 3) / 4;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_AFTER     = 400;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LIMIT_CYCLES   = 3_000_000;

  typedef struct {
    ttcg_op_t    op;
    logic [7:0]  char_code;
    logic [11:0] font_index;
    logic [7:0]  font_data;
  } term_req_t;

  typedef struct {
    logic [31:0] pixel_word;
    logic        line_end;
    logic        frame_end;
    logic [5:0]  cursor_column;
    logic [3:0]  cursor_row;
  } term_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_NONE;
  logic [7:0]  in_char_code = '0;
  logic [11:0] in_font_index = '0;
  logic [7:0]  in_font_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_word;
  logic        out_line_end;
  logic        out_frame_end;
  logic [5:0]  out_cursor_column;
  logic [3:0]  out_cursor_row;

  term_req_t    pending_requests[$];
  term_result_t expected_screen_out[$];

  // Predicted terminal state
  bit [7:0] screen_codes [CELLS];
  bit [7:0] glyph_bytes [4096];
  bit       glyph_loaded [4096];
  int       cur_col, cur_row;
  int       scan_addr, scan_line, word_idx;

  int n_sent, n_received, errors;
  int gap_left, stall_left, hold_left;
  bit hold_done;
  int next_stall;

  text_terminal_character_generator_top #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .GLYPH_LINES (GLYPH_LINES)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_char_code      (in_char_code),
    .in_font_index     (in_font_index),
    .in_font_data      (in_font_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_word    (out_pixel_word),
    .out_line_end      (out_line_end),
    .out_frame_end     (out_frame_end),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cursor handling for one put-character request
  task automatic put_on_screen(input logic [7:0] code);
    int i;
    screen_codes[cur_col + cur_row * COLUMNS] = BLANK_CODE;
    if (code == CODE_CLEAR) begin
      for (i = 0; i < CELLS; i++) screen_codes[i] = BLANK_CODE;
      cur_col = 0;
      cur_row = 0;
    end else if (code == CODE_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (code == CODE_BACKSPACE) begin
      if (cur_col > 0) cur_col--;
    end else begin
      screen_codes[cur_col + cur_row * COLUMNS] = code;
      cur_col++;
    end
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    // Scroll up one row, blank the bottom row
    if (cur_row >= ROWS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) screen_codes[i] = screen_codes[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) screen_codes[i] = BLANK_CODE;
      cur_row = ROWS - 1;
    end
    screen_codes[cur_col + cur_row * COLUMNS] = CURSOR_CODE;
  endtask

  // Next raster word: four glyph bytes, then advance the walk
  task automatic fetch_raster_word(output term_result_t res);
    int row_base, k, c;
    logic [7:0] b;
    res.line_end  = 1'b0;
    res.frame_end = 1'b0;
    row_base = scan_addr - word_idx * 4;
    for (k = 0; k < 4; k++) begin
      c = word_idx * 4 + k;
      b = '0;
      if (c < COLUMNS && row_base + c < CELLS)
        b = glyph_bytes[12'(scan_line * 256 + screen_codes[row_base + c])];
      res.pixel_word[31 - 8 * k -: 8] = b;
    end
    word_idx++;
    scan_addr += 4;
    if (word_idx >= WORDS_PER_LINE) begin
      res.line_end = 1'b1;
      word_idx = 0;
      if (scan_line + 1 < GLYPH_LINES) begin
        scan_line++;
        scan_addr = row_base;
      end else begin
        scan_line = 0;
        scan_addr = row_base + COLUMNS;
        if (scan_addr >= CELLS) begin
          res.frame_end = 1'b1;
          scan_addr = 0;
        end
      end
    end
  endtask

  // Predict the result of one request and queue it
  task automatic terminal_step(input term_req_t r);
    term_result_t res;
    res.pixel_word = '0;
    res.line_end   = 1'b0;
    res.frame_end  = 1'b0;
    case (r.op)
      OP_PUT: put_on_screen(r.char_code);
      OP_FETCH: fetch_raster_word(res);
      OP_LOAD: begin
        glyph_bytes[r.font_index]  = r.font_data;
        glyph_loaded[r.font_index] = 1'b1;
      end
      default: ;
    endcase
    res.cursor_column = 6'(cur_col);
    res.cursor_row    = 4'(cur_row);
    expected_screen_out.push_back(res);
  endtask

  task automatic issue(input ttcg_op_t op, input logic [7:0] code,
                       input logic [11:0] fidx, input logic [7:0] fdata);
    term_req_t r;
    r.op         = op;
    r.char_code  = code;
    r.font_index = fidx;
    r.font_data  = fdata;
    pending_requests.push_back(r);
    terminal_step(r);
  endtask

  task automatic issue_put(input logic [7:0] code);
    issue(OP_PUT, code, 12'($urandom), 8'($urandom));
  endtask

  task automatic issue_load(input logic [11:0] fidx, input logic [7:0] fdata);
    issue(OP_LOAD, 8'($urandom), fidx, fdata);
  endtask

  // A fetch may only read loaded glyph bytes: load any missing ones first
  task automatic issue_fetch();
    int row_base, k, c;
    logic [11:0] fidx;
    row_base = scan_addr - word_idx * 4;
    for (k = 0; k < 4; k++) begin
      c = word_idx * 4 + k;
      if (c < COLUMNS && row_base + c < CELLS) begin
        fidx = 12'(scan_line * 256 + screen_codes[row_base + c]);
        if (!glyph_loaded[fidx]) issue_load(fidx, 8'($urandom));
      end
    end
    issue(OP_FETCH, 8'($urandom), 12'($urandom), 8'($urandom));
  endtask

  // Mostly a small alphabet, with control codes and the odd arbitrary code
  function automatic logic [7:0] pick_put_code();
    int r;
    r = $urandom_range(0, 199);
    if (r < 16) return CODE_NEWLINE;
    if (r < 22) return CODE_BACKSPACE;
    if (r < 23) return CODE_CLEAR;
    if (r < 33) return 8'($urandom_range(0, 255));
    if (r < 45) return BLANK_CODE;
    return 8'($urandom_range(65, 80));
  endfunction

  // Idle length: quiet stretches with none, otherwise mostly short
  function automatic int pick_idle(input int count);
    int r;
    if ((count / 150) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      n_sent   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) n_sent <= n_sent + 1;
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        in_valid      <= 1'b1;
        in_operation  <= pending_requests[0].op;
        in_char_code  <= pending_requests[0].char_code;
        in_font_index <= pending_requests[0].font_index;
        in_font_data  <= pending_requests[0].font_data;
        void'(pending_requests.pop_front());
        gap_left <= pick_idle(n_sent);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once traffic is running, so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and ready generation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      n_received <= 0;
      errors     <= 0;
    end else begin
      next_stall = stall_left;
      if (out_valid && out_ready) begin
        n_received <= n_received + 1;
        if (expected_screen_out.size() == 0) begin
          if (errors < 10)
            $display("ERROR: result with no request outstanding: word %h col %0d row %0d",
                     out_pixel_word, out_cursor_column, out_cursor_row);
          errors <= errors + 1;
        end else begin
          if (out_pixel_word !== expected_screen_out[0].pixel_word ||
              out_line_end !== expected_screen_out[0].line_end ||
              out_frame_end !== expected_screen_out[0].frame_end ||
              out_cursor_column !== expected_screen_out[0].cursor_column ||
              out_cursor_row !== expected_screen_out[0].cursor_row) begin
            if (errors < 10) begin
              $write("ERROR: result %0d: expected word %h le %b fe %b col %0d row %0d,",
                     n_received,
                     expected_screen_out[0].pixel_word, expected_screen_out[0].line_end,
                     expected_screen_out[0].frame_end,
                     expected_screen_out[0].cursor_column,
                     expected_screen_out[0].cursor_row);
              $display(" got word %h le %b fe %b col %0d row %0d",
                       out_pixel_word, out_line_end,
                       out_frame_end, out_cursor_column, out_cursor_row);
            end
            errors <= errors + 1;
          end
          void'(expected_screen_out.pop_front());
        end
        next_stall = pick_idle(n_received + 75);
      end else if (stall_left > 0) begin
        next_stall = stall_left - 1;
      end
      stall_left <= next_stall;
      out_ready  <= (next_stall == 0) && (hold_left == 0);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int i, r;
    for (i = 0; i < CELLS; i++) screen_codes[i] = BLANK_CODE;
    for (i = 0; i < 4096; i++) glyph_loaded[i] = 1'b0;
    cur_col = 0;
    cur_row = 0;
    scan_addr = 0;
    scan_line = 0;
    word_idx = 0;

    // Directed: font extremes, control codes at edges, unused operation
    issue_load(12'h000, 8'h00);
    issue_load(12'hFFF, 8'hFF);
    issue_load(12'hAAA, 8'h55);
    issue_put(CODE_BACKSPACE);
    issue_put(8'd72);
    issue_put(8'd73);
    issue_put(CODE_BACKSPACE);
    issue_put(8'd0);
    issue_put(8'd255);
    issue_put(CURSOR_CODE);
    issue_put(BLANK_CODE);
    issue_put(CODE_NEWLINE);
    issue(OP_NONE, 8'hFF, 12'hFFF, 8'hFF);
    issue_fetch();
    issue_fetch();
    issue_put(CODE_CLEAR);
    issue_put(8'd90);
    issue(OP_NONE, 8'h00, 12'h000, 8'h00);
    issue_fetch();

    // Random: fetch-heavy until enough requests
    while (pending_requests.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 62) issue_fetch();
      else if (r < 90) issue_put(pick_put_code());
      else if (r < 98) issue_load(12'($urandom), 8'($urandom));
      else issue(OP_NONE, 8'($urandom), 12'($urandom), 8'($urandom));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_screen_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("text_terminal_character_generator_top regression: pass");
    end else begin
      $display("text_terminal_character_generator_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(4 * LIMIT_CYCLES);
    $display("text_terminal_character_generator_top regression: fail");
    $finish;
  end

endmodule
